// ----- hdl/adrp_add_address_resolver_macros.svh -----
// Assertion macros shared by the address resolver RTL.
// Depends on nothing; users provide clk and rst in scope.
`ifndef ADRP_ADD_ADDRESS_RESOLVER_MACROS_SVH
`define ADRP_ADD_ADDRESS_RESOLVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ADRP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adrp assertion failed");

// Next-cycle implication, checked outside reset.
`define ADRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adrp assertion failed");

`endif

// ----- hdl/adrp_pkg.sv -----
// Types and constants for the ADRP/ADD address resolver.
// No dependencies; imported by every module of the block.
package adrp_pkg;

  // Input word: one instruction of the scan
  typedef struct packed {
    logic [31:0] insn_word;
    logic [63:0] insn_address;
    logic        last_in_scan;
  } adrp_in_t;

  // Output word: one result per scan
  typedef struct packed {
    logic [63:0] resolved_address;
    logic        found;
  } adrp_out_t;

  // Scan phase, one-hot
  typedef enum logic [2:0] {
    PH_SEARCHING = 3'b001,
    PH_LOOKING   = 3'b010,
    PH_DONE      = 3'b100
  } adrp_phase_t;

  // Register map
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_IDX_TARGET = 1'b0;

  // Instruction decode masks and patterns
  localparam logic [31:0] ADR_CLASS_MASK = 32'h9F00_0000;
  localparam logic [31:0] ADRP_PATTERN   = 32'h9000_0000;
  localparam logic [31:0] ADR_PATTERN    = 32'h1000_0000;
  localparam logic [7:0]  ADD_IMM_OPCODE = 8'h91;

endpackage

// ----- hdl/adrp_apb_regs.sv -----
// APB-style configuration register file: holds the tracked register number.
// Depends on adrp_pkg.
module adrp_apb_regs import adrp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [4:0]         target_register
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_IDX_TARGET);

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      target_register <= 5'd0;
    end else if (wr_en) begin
      target_register <= pwdata[4:0];
    end
  end

  // Read back
  always_comb begin
    if (paddr[PADDR_W-1] == REG_IDX_TARGET) begin
      prdata = {27'd0, target_register};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

// ----- hdl/adrp_in_stage.sv -----
// Input register stage: captures one instruction word per cycle unless stalled.
// Depends on adrp_pkg.
module adrp_in_stage import adrp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  adrp_in_t in_data,
  input  logic     take,
  output logic     item_valid,
  output adrp_in_t item
);

  logic accept;

  // Stall only while holding a word the next stage cannot take
  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
  end

endmodule

// ----- hdl/adrp_resolve.sv -----
// Decode, scan state and result register of the address resolver.
// Depends on adrp_pkg and the assertion macro header.
`include "adrp_add_address_resolver_macros.svh"
module adrp_resolve import adrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [4:0] target_register,
  input  logic       item_valid,
  input  adrp_in_t   item,
  output logic       take,
  output logic       out_valid,
  input  logic       out_stall,
  output adrp_out_t  out_data
);

  adrp_phase_t phase, phase_next, phase_mid;
  logic [63:0] page_base;

  logic [31:0] w;
  logic [63:0] pc;
  logic        rd_match, rn_match;
  logic        is_adrp, is_adr, is_add;
  logic        add_hit, search_on, adrp_hit, adr_hit, hit, emit;
  logic        phase_done;
  logic [20:0] imm21;
  logic [63:0] imm_sext, add_imm;
  logic [63:0] adrp_page, adr_addr, add_addr, hit_addr;

  assign w  = item.insn_word;
  assign pc = item.insn_address;

  // Result register has room when empty or being drained
  assign take = item_valid && (!out_valid || !out_stall);

  // Field decode
  assign rd_match = (w[4:0] == target_register);
  assign rn_match = (w[9:5] == target_register);
  assign is_adrp  = ((w & ADR_CLASS_MASK) == ADRP_PATTERN);
  assign is_adr   = ((w & ADR_CLASS_MASK) == ADR_PATTERN);
  assign is_add   = (w[31:24] == ADD_IMM_OPCODE);

  // 21-bit PC-relative immediate, immhi:immlo
  assign imm21    = {w[23:5], w[30:29]};
  assign imm_sext = {{43{imm21[20]}}, imm21};
  assign add_imm  = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};

  // The three candidate addresses
  assign adrp_page = {pc[63:12], 12'd0} + {imm_sext[51:0], 12'd0};
  assign adr_addr  = pc + imm_sext;
  assign add_addr  = page_base + add_imm;

  // Match logic; a stray write to the register ends the look and is re-decoded
  always_comb begin
    phase_done = 1'b0;
    add_hit    = 1'b0;
    search_on  = 1'b0;
    case (phase)
      PH_SEARCHING: begin
        search_on = 1'b1;
      end
      PH_LOOKING: begin
        add_hit   = is_add && rn_match && rd_match;
        search_on = !add_hit && rd_match;
      end
      default: begin
        phase_done = 1'b1;
      end
    endcase
  end

  assign adrp_hit = search_on && rd_match && is_adrp;
  assign adr_hit  = search_on && rd_match && is_adr;
  assign hit      = add_hit || adr_hit;
  assign hit_addr = add_hit ? add_addr : adr_addr;
  assign emit     = hit || (item.last_in_scan && !phase_done);

  // Phase update
  always_comb begin
    if (hit) begin
      phase_mid = PH_DONE;
    end else if (adrp_hit) begin
      phase_mid = PH_LOOKING;
    end else if (search_on) begin
      phase_mid = PH_SEARCHING;
    end else begin
      phase_mid = phase;
    end
    phase_next = item.last_in_scan ? PH_SEARCHING : phase_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEARCHING;
      page_base <= 64'd0;
    end else if (take) begin
      phase <= phase_next;
      if (adrp_hit) begin
        page_base <= adrp_page;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_data.resolved_address <= hit ? hit_addr : 64'd0;
      out_data.found            <= hit;
    end
  end

  `ADRP_ASSERT_NOW(a_notfound_zero, out_valid && !out_data.found,
                   out_data.resolved_address == 64'd0)
  `ADRP_ASSERT_NEXT(a_last_rearms, take && item.last_in_scan, phase == PH_SEARCHING)
  `ADRP_ASSERT_NEXT(a_hit_done, take && hit && !item.last_in_scan, phase == PH_DONE)
  `ADRP_ASSERT_NEXT(a_result_loaded, take && emit, out_valid && (out_data.found == $past(hit)))

endmodule

// ----- hdl/adrp_add_address_resolver.sv -----
// ADRP/ADD address resolver, top level.
// Channels: in_valid/in_stall/in_data carries one instruction word with its
// byte address and an end-of-scan flag; out_valid/out_stall/out_data carries
// one result word per scan (resolved_address, found). An APB-style port at
// byte address 0 holds the tracked register number (5 bits).
// Throughput: one instruction word per cycle while the output is not stalled.
// A word is captured in the input register and decoded there; its result is
// loaded into the output register when the word is taken, so out_valid follows
// the word that resolves the scan (or the last word) through both registers.
// Words that produce no result never occupy the output register.
// Reset (synchronous) clears the register number to 0, empties both stages
// and returns the scan to searching with a zero page base.
// While out_valid and out_stall are high the result word holds; one further
// word may still enter the input register, and in_stall then stays high
// (whether or not that word produces a result) until the result moves on.
// Depends on adrp_pkg, adrp_apb_regs, adrp_in_stage, adrp_resolve.
module adrp_add_address_resolver import adrp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  adrp_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output adrp_out_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [4:0] target_register;
  logic       item_valid;
  logic       take;
  adrp_in_t   item;

  adrp_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .target_register (target_register)
  );

  adrp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  adrp_resolve u_resolve (
    .clk             (clk),
    .rst             (rst),
    .target_register (target_register),
    .item_valid      (item_valid),
    .item            (item),
    .take            (take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

endmodule
